FILE: hw/rtl/nps_pkg.sv
package nps_pkg;

  // Fixed field widths of the request and response.
  localparam int unsigned START_W = 30;
  localparam int unsigned PRIME_W = 31;

  // Default number of start value bits that are used.
  localparam int unsigned START_BITS_DEF = 30;

  // Remainder bits retired per division cycle.
  localparam int unsigned RADIX_BITS = 4;

  typedef struct packed {
    logic load;       // latch request, form first candidate
    logic next_cand;  // candidate += 2, divisor back to 3
    logic div_start;  // begin remainder of candidate by divisor
    logic div_step;   // retire RADIX_BITS remainder bits
    logic next_div;   // divisor += 2, square updated
    logic out_load;   // capture candidate as result
  } nps_cmd_t;

  typedef struct packed {
    logic sq_gt;      // divisor squared exceeds candidate
    logic div_last;   // current step is the last one
    logic rem_zero;   // remainder is zero
  } nps_sts_t;

endpackage

FILE: hw/rtl/nps_if.sv
interface nps_in_if;
  import nps_pkg::*;

  logic               valid;
  logic               ready;
  logic [START_W-1:0] start_value;

  modport source (output valid, output start_value, input ready);
  modport sink   (input valid, input start_value, output ready);
endinterface

interface nps_out_if;
  import nps_pkg::*;

  logic               valid;
  logic               ready;
  logic [PRIME_W-1:0] prime;

  modport source (output valid, output prime, input ready);
  modport sink   (input valid, input prime, output ready);
endinterface

FILE: hw/rtl/next_prime_search_unit.sv
// Next prime search. A request carries a start value; its low START_BITS bits, forced odd and
// plus 2, give the first candidate, and the response is the smallest prime at or above it.
// Each candidate is tested by trial division with odd divisors 3, 5, 7, ... while the divisor
// squared is at most the candidate; a composite steps the candidate by 2. One request is worked
// at a time. The shared restoring divider retires 4 remainder bits a cycle. A prime p near 2^30
// takes about 16,400 divisors, and a search runs through the divisors of every candidate tried.
// A finished response waits in an output register while the next request is taken.
module next_prime_search_unit #(
  parameter int unsigned START_BITS = nps_pkg::START_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nps_in_if.sink    req_i,
  nps_out_if.source rsp_o
);
  import nps_pkg::*;

  nps_cmd_t cmd;
  nps_sts_t sts;

  nps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  nps_dp #(
    .START_BITS (START_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .start_value_i (req_i.start_value),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .prime_o       (rsp_o.prime)
  );

endmodule

FILE: hw/rtl/nps_ctrl.sv
module nps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  input  nps_pkg::nps_sts_t sts_i,
  output nps_pkg::nps_cmd_t cmd_o
);
  import nps_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_EVAL  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.sq_gt) begin
          // no divisor left: candidate is prime; wait for a free output slot
          if (out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts_i.rem_zero) begin
          cmd_o.next_cand = 1'b1;
        end else begin
          cmd_o.next_div = 1'b1;
        end
        state_d = ST_CHECK;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hw/rtl/nps_dp.sv
module nps_dp #(
  parameter int unsigned START_BITS = nps_pkg::START_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic [nps_pkg::START_W-1:0] start_value_i,
  input  nps_pkg::nps_cmd_t           cmd_i,
  output nps_pkg::nps_sts_t           sts_o,
  output logic [nps_pkg::PRIME_W-1:0] prime_o
);
  import nps_pkg::*;

  // candidate, divisor, square, remainder and dividend shift widths
  localparam int unsigned CW     = START_BITS + 1;
  localparam int unsigned DW     = (CW + 1) / 2 + 1;
  localparam int unsigned SW     = 2 * DW;
  localparam int unsigned RW     = DW + 1;
  localparam int unsigned NSTEP  = (CW + RADIX_BITS - 1) / RADIX_BITS;
  localparam int unsigned PW     = NSTEP * RADIX_BITS;
  localparam int unsigned CNT_W  = $clog2(NSTEP);

  logic [CW-1:0]    cand_q, cand_d;
  logic [DW-1:0]    div_q, div_d;
  logic [SW-1:0]    sq_q, sq_d;
  logic [RW-1:0]    rem_q, rem_d, rem_nx;
  logic [PW-1:0]    sh_q, sh_d, sh_nx;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PRIME_W-1:0] prime_q, prime_d;
  logic [START_BITS-1:0] start_low;

  assign start_low = start_value_i[START_BITS-1:0];

  // restoring division, RADIX_BITS quotient bits per cycle
  always_comb begin
    rem_nx = rem_q;
    sh_nx  = sh_q;
    for (int k = 0; k < RADIX_BITS; k++) begin
      rem_nx = {rem_nx[RW-2:0], sh_nx[PW-1]};
      sh_nx  = {sh_nx[PW-2:0], 1'b0};
      if (rem_nx >= {1'b0, div_q}) begin
        rem_nx = rem_nx - {1'b0, div_q};
      end
    end
  end

  always_comb begin
    cand_d  = cand_q;
    div_d   = div_q;
    sq_d    = sq_q;
    rem_d   = rem_q;
    sh_d    = sh_q;
    cnt_d   = cnt_q;
    prime_d = prime_q;
    if (cmd_i.load) begin
      cand_d = {1'b0, start_low[START_BITS-1:1], 1'b1} + CW'(2);
    end else if (cmd_i.next_cand) begin
      cand_d = cand_q + CW'(2);
    end
    if (cmd_i.load || cmd_i.next_cand) begin
      div_d = DW'(3);
      sq_d  = SW'(9);
    end else if (cmd_i.next_div) begin
      // (d+2)^2 = d^2 + 4d + 4
      div_d = div_q + DW'(2);
      sq_d  = sq_q + SW'({div_q, 2'b00}) + SW'(4);
    end
    if (cmd_i.div_start) begin
      rem_d = '0;
      sh_d  = PW'(cand_q);
      cnt_d = '0;
    end else if (cmd_i.div_step) begin
      rem_d = rem_nx;
      sh_d  = sh_nx;
      cnt_d = cnt_q + CNT_W'(1);
    end
    if (cmd_i.out_load) begin
      prime_d = PRIME_W'(cand_q);
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q  <= cand_d;
    div_q   <= div_d;
    sq_q    <= sq_d;
    rem_q   <= rem_d;
    sh_q    <= sh_d;
    cnt_q   <= cnt_d;
    prime_q <= prime_d;
  end

  assign sts_o.sq_gt    = (sq_q > SW'(cand_q));
  assign sts_o.div_last = (cnt_q == CNT_W'(NSTEP - 1));
  assign sts_o.rem_zero = (rem_q == '0);
  assign prime_o        = prime_q;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import nps_pkg::*;

  localparam int unsigned SEARCH_BITS = START_BITS_DEF;
  localparam logic [START_W-1:0] START_MASK = START_W'((64'd1 << SEARCH_BITS) - 64'd1);
  localparam int unsigned RANDOM_REQUESTS = 100;
  localparam int unsigned HOLD_OFF_CYCLES = 1500;
  localparam int unsigned DRAIN_CYCLES = 50;
  localparam longint unsigned CYCLE_LIMIT = 20_000_000;

  typedef enum int {
    RSP_ALWAYS,
    RSP_HALF,
    RSP_SPARSE
  } rsp_mode_e;

  // Expected primes in request order; the oldest one is matched to each response.
  class prime_scoreboard;
    logic [PRIME_W-1:0] expected_primes[$];
    int unsigned mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    static function logic [PRIME_W-1:0] next_prime_from(logic [START_W-1:0] start);
      longint unsigned cand;
      longint unsigned divisor;
      bit composite;
      cand = 64'(start & START_MASK) | 64'd1;
      cand = cand + 64'd2;
      do begin
        composite = 1'b0;
        for (divisor = 3; divisor * divisor <= cand && !composite; divisor += 2) begin
          if (cand % divisor == 0) composite = 1'b1;
        end
        if (composite) cand = cand + 64'd2;
      end while (composite);
      return cand[PRIME_W-1:0];
    endfunction

    function void note_request(logic [START_W-1:0] start);
      expected_primes.push_back(next_prime_from(start));
    endfunction

    function void check_response(logic [PRIME_W-1:0] prime);
      logic [PRIME_W-1:0] expected;
      if (expected_primes.size() == 0) begin
        $error("prime: response %0d with no request pending", prime);
        mismatch_count++;
      end else begin
        expected = expected_primes.pop_front();
        if (expected !== prime) begin
          $error("prime mismatch: expected %0d, actual %0d", expected, prime);
          mismatch_count++;
        end
      end
    endfunction

    function int pending();
      return expected_primes.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  nps_in_if  req_if ();
  nps_out_if rsp_if ();

  next_prime_search_unit #(
    .START_BITS(SEARCH_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  prime_scoreboard prime_sb = new();
  int unsigned rsp_hold_cycles = 0;
  longint unsigned cycle_count = 0;

  logic [START_W-1:0] directed_starts[$] = '{
    30'd0, 30'd1, 30'd2, 30'd3, 30'd4, 30'd5, 30'd6, 30'd7, 30'd8, 30'd13, 30'd23,
    30'd113, 30'h3FF, 30'hFFFF, 30'h2AAAA, 30'h15555, 30'h3FFFFFFF
  };

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) prime_sb.note_request(req_if.start_value);
      if (rsp_if.valid && rsp_if.ready) prime_sb.check_response(rsp_if.prime);
    end
  end

  // Receiver: stall pattern is picked at random and changes when its run ends; a pending hold-off wins.
  initial begin
    rsp_mode_e mode;
    int unsigned mode_left;
    mode = RSP_ALWAYS;
    mode_left = 0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rsp_hold_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        rsp_hold_cycles--;
      end else begin
        if (mode_left == 0) begin
          mode = rsp_mode_e'($urandom_range(RSP_SPARSE));
          mode_left = $urandom_range(16, 80);
        end
        mode_left--;
        case (mode)
          RSP_ALWAYS: rsp_if.ready <= 1'b1;
          RSP_HALF:   rsp_if.ready <= 1'($urandom_range(1));
          default:    rsp_if.ready <= ($urandom_range(3) == 0);
        endcase
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic [START_W-1:0] start);
    req_if.valid <= 1'b1;
    req_if.start_value <= start;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (prime_sb.pending() != 0) @(negedge clk_i);
  endtask

  // Mostly narrow values keep searches short; a few wide ones exercise long searches.
  function automatic logic [START_W-1:0] random_start(int unsigned max_bits);
    int unsigned width;
    width = $urandom_range(1, max_bits);
    return START_W'($urandom) & START_W'((64'd1 << width) - 64'd1);
  endfunction

  initial begin
    int unsigned burst_left;
    int unsigned gap;
    int unsigned no_gap_left;
    int unsigned max_bits;
    burst_left = 0;
    no_gap_left = 0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.start_value = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_starts[i]) send_request(directed_starts[i]);
    wait_drained();

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == 30) begin
        // long receiver hold-off while requests keep coming back to back
        rsp_hold_cycles = HOLD_OFF_CYCLES;
        no_gap_left = 10;
      end
      if (i == 70) wait_drained();
      if (no_gap_left > 0) begin
        no_gap_left--;
        max_bits = 12;
      end else begin
        max_bits = ($urandom_range(99) < 5) ? 26 : 18;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
          if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk_i);
          end
        end
        burst_left--;
      end
      send_request(random_start(max_bits));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (prime_sb.mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
